>>> hw/rtl/peh_pkg.sv
// -----------------------------------------------------------------------------
// Event histogrammer package
// Shared constants, command and result types, and the counter update helper.
// -----------------------------------------------------------------------------
`default_nettype none

package peh_pkg;

    // Store geometry.
    localparam int ENERGY_BINS = 1024;
    localparam int MASS_BINS   = 512;
    localparam int Z_BINS      = 128;
    localparam int EA_W        = $clog2(ENERGY_BINS);
    localparam int MA_W        = $clog2(MASS_BINS);
    localparam int ZA_W        = $clog2(Z_BINS);
    localparam int NA_W        = MA_W + ZA_W;

    // Field widths.
    localparam int CNT_W    = 32;
    localparam int ENERGY_W = 40;
    localparam int CW_W     = 32;
    localparam int NCH_W    = 11;

    localparam logic [CNT_W-1:0] CNT_MAX        = '1;
    localparam logic [CW_W-1:0]  WIDTH_RESET    = 32'd5000000;
    localparam logic [NCH_W-1:0] CHANNELS_RESET = 11'd50;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CHANNEL_WIDTH = 2'd0;
    localparam logic [1:0] CFG_NUM_CHANNELS  = 2'd1;

    typedef enum logic [1:0] {
        FN_RECORD = 2'd0,
        FN_READ   = 2'd1,
        FN_CLEAR  = 2'd2,
        FN_NOP    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        SEL_ENERGY  = 2'd0,
        SEL_MASS    = 2'd1,
        SEL_NUCLIDE = 2'd2,
        SEL_NONE    = 2'd3
    } t_sel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_UPDATE,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        t_func                func;
        t_sel                 sel;
        logic [ENERGY_W-1:0]  energy;
        logic [MA_W-1:0]      mass;
        logic [ZA_W-1:0]      z;
        logic [EA_W-1:0]      bin;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [EA_W-1:0]  chan;
    } t_result;

    // Saturating increment of one count.
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] cnt);
        return (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/particle_event_histogrammer.sv
// -----------------------------------------------------------------------------
// Particle event histogrammer
// Bins recoil events by energy, mass and nuclide with saturating counts.
// -----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  events    in         push / full             func, table_select, energy_ev,
//                                               mass_number, atomic_number, bin_index
//  results   out        empty / pop             count, energy_channel
//  config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  A record runs the 40-step restoring divider, then the read and update
//  states of the count stores. A read passes through the read and update states;
//  a no-operation item pushes its result into the result queue as it is taken.
//  A clear sweeps the 65536 nuclide entries, one a cycle; the same sweep runs
//  after reset, and no command is carried out until it ends.
//  The front queue keeps taking up to two transactions while the back stalls.
// -----------------------------------------------------------------------------
`default_nettype none

module particle_event_histogrammer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_func,
    input  wire logic [1:0]  i_table_select,
    input  wire logic [39:0] i_energy_ev,
    input  wire logic [8:0]  i_mass_number,
    input  wire logic [6:0]  i_atomic_number,
    input  wire logic [9:0]  i_bin_index,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      o_count,
    output logic [9:0]       o_energy_channel,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import peh_pkg::*;

    logic [CW_W-1:0]     r_channel_width;
    logic [NCH_W-1:0]    r_num_channels;
    logic                w_cmd_valid, w_cmd_take, w_div_start, w_div_busy, w_div_done;
    t_cmd                w_cmd;
    t_result             w_result;
    logic [ENERGY_W-1:0] w_dividend, w_quotient;
    logic [CW_W-1:0]     w_divisor;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_width <= WIDTH_RESET;
            r_num_channels  <= CHANNELS_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_CHANNEL_WIDTH) begin
                r_channel_width <= i_cfg_data;
            end else if (i_cfg_index == CFG_NUM_CHANNELS) begin
                r_num_channels <= i_cfg_data[NCH_W-1:0];
            end
        end
    end

    peh_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_func          (i_func),
        .i_table_select  (i_table_select),
        .i_energy_ev     (i_energy_ev),
        .i_mass_number   (i_mass_number),
        .i_atomic_number (i_atomic_number),
        .i_bin_index     (i_bin_index),
        .o_cmd_valid     (w_cmd_valid),
        .o_cmd           (w_cmd),
        .i_cmd_take      (w_cmd_take)
    );

    peh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    peh_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (w_cmd_valid),
        .i_cmd           (w_cmd),
        .o_cmd_take      (w_cmd_take),
        .i_channel_width (r_channel_width),
        .i_num_channels  (r_num_channels),
        .o_div_start     (w_div_start),
        .o_dividend      (w_dividend),
        .o_divisor       (w_divisor),
        .i_div_done      (w_div_done),
        .i_quotient      (w_quotient),
        .empty           (empty),
        .pop             (pop),
        .o_result        (w_result)
    );

    assign o_count          = w_result.count;
    assign o_energy_channel = w_result.chan;

    // The back end only takes a command that the front queue holds.
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_take |-> w_cmd_valid) else $error("command taken from empty queue");

    // A division is never started while one is running.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy) else $error("divider restarted while busy");

    // A started division keeps the divider busy in the next cycle.
    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> w_div_busy && !w_div_done) else $error("divider did not start");

    // No new command is taken while a division is still running.
    a_no_take_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> !w_cmd_take) else $error("command taken during division");

endmodule

`default_nettype wire

>>> hw/rtl/peh_front.sv
// -----------------------------------------------------------------------------
// Event histogrammer front end
// Accepts transactions, classifies them and holds them in a two-entry queue.
// -----------------------------------------------------------------------------
`default_nettype none

module peh_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire logic [1:0]      i_func,
    input  wire logic [1:0]      i_table_select,
    input  wire logic [39:0]     i_energy_ev,
    input  wire logic [8:0]      i_mass_number,
    input  wire logic [6:0]      i_atomic_number,
    input  wire logic [9:0]      i_bin_index,
    output logic                 o_cmd_valid,
    output peh_pkg::t_cmd        o_cmd,
    input  wire logic            i_cmd_take
);
    import peh_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_wr, w_rd;

    // Classify the incoming transaction.
    always_comb begin
        w_cmd.func   = t_func'(i_func);
        w_cmd.sel    = t_sel'(i_table_select);
        w_cmd.energy = i_energy_ev;
        w_cmd.mass   = i_mass_number;
        w_cmd.z      = i_atomic_number;
        w_cmd.bin    = i_bin_index;
    end

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_wr        = push && !full;
    assign w_rd        = i_cmd_take && o_cmd_valid;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/peh_div.sv
// -----------------------------------------------------------------------------
// Event histogrammer divider
// Restoring divider, one quotient bit per cycle; a zero divisor gives all ones.
// -----------------------------------------------------------------------------
`default_nettype none

module peh_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [peh_pkg::ENERGY_W-1:0] i_dividend,
    input  wire logic [peh_pkg::CW_W-1:0]     i_divisor,
    output logic                             o_busy,
    output logic                             o_done,
    output logic [peh_pkg::ENERGY_W-1:0]      o_quotient
);
    import peh_pkg::*;

    localparam int STEP_W = $clog2(ENERGY_W);

    logic                r_busy, r_done;
    logic [STEP_W-1:0]   r_step;
    logic [CW_W:0]       r_rem;
    logic [ENERGY_W-1:0] r_quo;
    logic [CW_W-1:0]     r_div;
    logic [CW_W:0]       w_sh;
    logic [CW_W+1:0]     w_diff;
    logic                w_ok;

    // One trial subtraction.
    always_comb begin
        w_sh   = {r_rem[CW_W-1:0], r_quo[ENERGY_W-1]};
        w_diff = {1'b0, w_sh} - {2'b00, r_div};
        w_ok   = !w_diff[CW_W+1];
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ok ? w_diff[CW_W:0] : w_sh;
            r_quo <= {r_quo[ENERGY_W-2:0], w_ok};
        end
    end

    // Step control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(ENERGY_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

>>> hw/rtl/peh_back.sv
// -----------------------------------------------------------------------------
// Event histogrammer back end
// Sequences record, read and clear commands over the three count stores and
// queues the results.
// -----------------------------------------------------------------------------
`default_nettype none

module peh_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cmd_valid,
    input  wire peh_pkg::t_cmd                i_cmd,
    output logic                              o_cmd_take,
    input  wire logic [peh_pkg::CW_W-1:0]      i_channel_width,
    input  wire logic [peh_pkg::NCH_W-1:0]     i_num_channels,
    output logic                              o_div_start,
    output logic [peh_pkg::ENERGY_W-1:0]       o_dividend,
    output logic [peh_pkg::CW_W-1:0]           o_divisor,
    input  wire logic                         i_div_done,
    input  wire logic [peh_pkg::ENERGY_W-1:0]  i_quotient,
    output logic                              empty,
    input  wire logic                         pop,
    output peh_pkg::t_result                  o_result
);
    import peh_pkg::*;

    t_state            r_state, n_state;
    t_cmd              r_cmd;
    logic [EA_W-1:0]   r_e_addr, r_chan;
    logic [MA_W-1:0]   r_m_addr;
    logic [NA_W-1:0]   r_n_addr, r_clr_addr;
    logic              r_clr_reply;

    logic [CNT_W-1:0]  e_mem [ENERGY_BINS];
    logic [CNT_W-1:0]  m_mem [MASS_BINS];
    logic [CNT_W-1:0]  n_mem [Z_BINS * MASS_BINS];
    logic [CNT_W-1:0]  r_e_rd, r_m_rd, r_n_rd;

    t_result           r_oq [2];
    logic              r_oq_wp, r_oq_rp;
    logic [1:0]        r_oq_cnt;

    logic              w_room, w_clr_last, w_we_rec, w_we_clr, w_res_push;
    logic [EA_W-1:0]   w_e_wa, w_chan;
    logic [MA_W-1:0]   w_m_wa;
    logic [NA_W-1:0]   w_n_wa;
    logic [CNT_W-1:0]  w_e_bump;
    logic [NCH_W-1:0]  w_nch, w_last;
    t_result           w_res;

    assign w_room     = (r_oq_cnt != 2'd2);
    assign w_clr_last = (r_clr_addr == '1);
    assign w_e_bump   = bump(r_e_rd);

    // Clamp the quotient to the channels in use.
    always_comb begin
        if (i_num_channels == '0) begin
            w_nch = NCH_W'(1);
        end else if (i_num_channels > NCH_W'(ENERGY_BINS)) begin
            w_nch = NCH_W'(ENERGY_BINS);
        end else begin
            w_nch = i_num_channels;
        end
        w_last = w_nch - 1'b1;
        w_chan = (i_quotient >= ENERGY_W'(w_nch)) ? w_last[EA_W-1:0] : i_quotient[EA_W-1:0];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && w_room) begin
                    unique case (i_cmd.func)
                        FN_RECORD: n_state = ST_DIV;
                        FN_READ:   n_state = ST_READ;
                        FN_CLEAR:  n_state = ST_CLEAR;
                        FN_NOP:    n_state = ST_IDLE;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DIV: begin
                if (i_div_done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ:   n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_IDLE;
            ST_CLEAR: begin
                if (w_clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_cmd_take  = (r_state == ST_IDLE) && i_cmd_valid && w_room;
        o_div_start = o_cmd_take && (i_cmd.func == FN_RECORD);
        w_we_rec    = (r_state == ST_UPDATE) && (r_cmd.func == FN_RECORD);
        w_we_clr    = (r_state == ST_CLEAR);
        w_res_push  = (o_cmd_take && (i_cmd.func == FN_NOP)) || (r_state == ST_UPDATE)
                      || (w_we_clr && w_clr_last && r_clr_reply);
        w_res       = '0;
        if (r_state == ST_UPDATE) begin
            if (r_cmd.func == FN_RECORD) begin
                w_res.count = w_e_bump;
                w_res.chan  = r_chan;
            end else begin
                // Every index field is exactly as wide as its store, so
                // only an unused selector reads back zero.
                unique case (r_cmd.sel)
                    SEL_ENERGY:  w_res.count = r_e_rd;
                    SEL_MASS:    w_res.count = r_m_rd;
                    SEL_NUCLIDE: w_res.count = r_n_rd;
                    SEL_NONE:    w_res.count = '0;
                    default:     w_res.count = '0;
                endcase
            end
        end
    end

    assign o_dividend = i_cmd.energy;
    assign o_divisor  = i_channel_width;
    assign w_e_wa     = w_we_clr ? r_clr_addr[EA_W-1:0] : r_e_addr;
    assign w_m_wa     = w_we_clr ? r_clr_addr[MA_W-1:0] : r_m_addr;
    assign w_n_wa     = w_we_clr ? r_clr_addr : r_n_addr;

    // Count stores: one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (w_we_clr || w_we_rec) begin
            e_mem[w_e_wa] <= w_we_clr ? '0 : w_e_bump;
            m_mem[w_m_wa] <= w_we_clr ? '0 : bump(r_m_rd);
            n_mem[w_n_wa] <= w_we_clr ? '0 : bump(r_n_rd);
        end
        r_e_rd <= e_mem[r_e_addr];
        r_m_rd <= m_mem[r_m_addr];
        r_n_rd <= n_mem[r_n_addr];
    end

    // Command and address registers.
    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd    <= i_cmd;
            r_e_addr <= i_cmd.bin;
            r_m_addr <= i_cmd.mass;
            r_n_addr <= {i_cmd.z, i_cmd.mass};
        end else if ((r_state == ST_DIV) && i_div_done) begin
            r_e_addr <= w_chan;
            r_chan   <= w_chan;
        end
    end

    // Control state and clearing sweep; reset starts a silent sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd_take && (i_cmd.func == FN_CLEAR)) begin
                r_clr_addr  <= '0;
                r_clr_reply <= 1'b1;
            end else if (w_we_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Result queue.
    always_ff @(posedge i_clk) begin
        if (w_res_push) begin
            r_oq[r_oq_wp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= 1'b0;
            r_oq_rp  <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            if (w_res_push) begin
                r_oq_wp <= ~r_oq_wp;
            end
            if (pop && !empty) begin
                r_oq_rp <= ~r_oq_rp;
            end
            r_oq_cnt <= r_oq_cnt + {1'b0, w_res_push} - {1'b0, pop && !empty};
        end
    end

    assign empty    = (r_oq_cnt == 2'd0);
    assign o_result = r_oq[r_oq_rp];

endmodule

`default_nettype wire

>>> bench/particle_event_histogrammer_tb.sv
// -----------------------------------------------------------------------------
// Particle event histogrammer testbench
// Drives event, read, clear and no-operation commands through the queue
// interface in bursts with random gaps. It pops results with random stalls and
// checks every result against a bit-exact model of the three count stores.
// The run steps through several channel width and channel count settings,
// the extremes among them.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module particle_event_histogrammer_tb;

    import peh_pkg::*;

    typedef struct {
        t_func       func;
        t_sel        sel;
        logic [39:0] energy;
        logic [8:0]  mass;
        logic [6:0]  z;
        logic [9:0]  bin;
    } t_event;

    typedef struct {
        logic [31:0] count;
        logic [9:0]  chan;
    } t_outcome;

    typedef struct {
        logic [1:0]  index;
        logic [31:0] data;
    } t_reg_write;

    // Clock, reset and block interface.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_func = '0;
    logic [1:0]  i_table_select = '0;
    logic [39:0] i_energy_ev = '0;
    logic [8:0]  i_mass_number = '0;
    logic [6:0]  i_atomic_number = '0;
    logic [9:0]  i_bin_index = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_count;
    logic [9:0]  o_energy_channel;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    // Model of the count stores and registers.
    logic [31:0] energy_store [ENERGY_BINS];
    logic [31:0] mass_store [MASS_BINS];
    logic [31:0] nuclide_store [Z_BINS*MASS_BINS];
    logic [31:0] model_width;
    logic [10:0] model_channels;

    t_event     pending_events [$];
    t_outcome   awaited_results [$];
    t_reg_write pending_writes [$];

    int  mismatches = 0;
    int  bursts_left = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  calm_left = 0;
    int  clears_left = 2;
    bit  hold_sender = 1'b0;

    particle_event_histogrammer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_func          (i_func),
        .i_table_select  (i_table_select),
        .i_energy_ev     (i_energy_ev),
        .i_mass_number   (i_mass_number),
        .i_atomic_number (i_atomic_number),
        .i_bin_index     (i_bin_index),
        .empty           (empty),
        .pop             (pop),
        .o_count         (o_count),
        .o_energy_channel(o_energy_channel),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Saturating increment of one stored count.
    function automatic logic [31:0] saturate_inc(input logic [31:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

    function automatic void wipe_stores();
        foreach (energy_store[i]) energy_store[i] = '0;
        foreach (mass_store[i]) mass_store[i] = '0;
        foreach (nuclide_store[i]) nuclide_store[i] = '0;
    endfunction

    // Applies one command to the model and returns the result it gives.
    function automatic t_outcome histogram_update(input t_event ev);
        t_outcome    res;
        logic [63:0] limit;
        logic [63:0] quot;
        logic [15:0] nidx;
        res.count = '0;
        res.chan  = '0;
        nidx = {ev.z, ev.mass};
        case (ev.func)
            FN_RECORD: begin
                limit = (model_channels == 0) ? 64'd1 : 64'(model_channels);
                if (limit > ENERGY_BINS) limit = 64'(ENERGY_BINS);
                quot = (model_width == 0) ? '1 : 64'(ev.energy) / 64'(model_width);
                if (quot >= limit) quot = limit - 64'd1;
                energy_store[quot[9:0]] = saturate_inc(energy_store[quot[9:0]]);
                res.count = energy_store[quot[9:0]];
                res.chan  = quot[9:0];
                mass_store[ev.mass] = saturate_inc(mass_store[ev.mass]);
                nuclide_store[nidx] = saturate_inc(nuclide_store[nidx]);
            end
            FN_READ: begin
                case (ev.sel)
                    SEL_ENERGY:  res.count = energy_store[ev.bin];
                    SEL_MASS:    res.count = mass_store[ev.mass];
                    SEL_NUCLIDE: res.count = nuclide_store[nidx];
                    default:     res.count = '0;
                endcase
            end
            FN_CLEAR: wipe_stores();
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_event make_event(input t_func f, input t_sel s,
                                          input logic [39:0] e, input int m,
                                          input int zn, input int b);
        t_event ev;
        ev.func = f;
        ev.sel = s;
        ev.energy = e;
        ev.mass = m[8:0];
        ev.z = zn[6:0];
        ev.bin = b[9:0];
        return ev;
    endfunction

    // Random command, weighted towards events on a few nuclides so that reads
    // find counts worth checking.
    function automatic t_event random_event();
        t_event ev;
        int     pick;
        int     mult;
        pick = $urandom_range(0, 99);
        ev.sel = t_sel'($urandom_range(0, 3));
        ev.bin = $urandom_range(0, 1) ? 10'($urandom_range(0, 63)) : 10'($urandom);
        ev.mass = $urandom_range(0, 3) != 0 ? 9'($urandom_range(0, 15)) : 9'($urandom);
        ev.z = $urandom_range(0, 3) != 0 ? 7'($urandom_range(0, 7)) : 7'($urandom);
        mult = $urandom_range(0, 80);
        case ($urandom_range(0, 3))
            0: ev.energy = 40'({$urandom, $urandom});
            1: ev.energy = 40'($urandom_range(0, 255));
            2: ev.energy = '1;
            default: ev.energy = 40'(64'(model_width) * mult + $urandom_range(0, 3));
        endcase
        if (pick < 60) ev.func = FN_RECORD;
        else if (pick < 92) ev.func = FN_READ;
        else if (pick < 97 || clears_left == 0) ev.func = FN_NOP;
        else begin
            ev.func = FN_CLEAR;
            clears_left--;
        end
        return ev;
    endfunction

    // Sender: bursts of commands with random gaps, optionally held off.
    always @(posedge i_clk) begin
        if (push && !full) awaited_results.push_back(histogram_update(pending_events.pop_front()));
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && full) begin
            push <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            push <= 1'b0;
        end else if (hold_sender || pending_events.size() == 0) begin
            push <= 1'b0;
        end else begin
            push            <= 1'b1;
            i_func          <= pending_events[0].func;
            i_table_select  <= pending_events[0].sel;
            i_energy_ev     <= pending_events[0].energy;
            i_mass_number   <= pending_events[0].mass;
            i_atomic_number <= pending_events[0].z;
            i_bin_index     <= pending_events[0].bin;
            if (bursts_left <= 1) begin
                bursts_left <= $urandom_range(1, 12);
                gap_left    <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                bursts_left <= bursts_left - 1;
            end
        end
    end

    // Register writes through their own channel.
    always @(posedge i_clk) begin
        if (i_cfg_valid && o_cfg_ready) begin
            if (pending_writes[0].index == CFG_CHANNEL_WIDTH) model_width = pending_writes[0].data;
            else if (pending_writes[0].index == CFG_NUM_CHANNELS)
                model_channels = pending_writes[0].data[10:0];
            void'(pending_writes.pop_front());
        end
        if (i_rst_n && pending_writes.size() > 0) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= pending_writes[0].index;
            i_cfg_data  <= pending_writes[0].data;
        end else begin
            i_cfg_valid <= 1'b0;
        end
    end

    // Receiver: checks each result, stalls in random stretches with calm spells.
    always @(posedge i_clk) begin
        t_outcome want;
        if (pop && !empty) begin
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result count=%h channel=%0d",
                             $realtime, o_count, o_energy_channel);
            end else begin
                want = awaited_results.pop_front();
                if (o_count !== want.count || o_energy_channel !== want.chan) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result mismatch: count %h, expected %h; channel %0d, expected %0d",
                                 $realtime, o_count, want.count, o_energy_channel, want.chan);
                end
            end
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (calm_left > 0) begin
            calm_left <= calm_left - 1;
            pop <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
            case ($urandom_range(0, 15))
                0, 1, 2: stall_left <= $urandom_range(1, 20);
                3:       calm_left <= $urandom_range(50, 300);
                default: ;
            endcase
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        t_reg_write w;
        w.index = idx;
        w.data = val;
        pending_writes.push_back(w);
    endtask

    // Waits, off the clock edge, until every register write and command is done.
    task automatic drain();
        @(negedge i_clk);
        while (pending_writes.size() > 0 || i_cfg_valid || pending_events.size() > 0
               || push || awaited_results.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic random_phase(input logic [31:0] width, input logic [31:0] chans,
                                input int n);
        write_reg(CFG_CHANNEL_WIDTH, width);
        write_reg(CFG_NUM_CHANNELS, chans);
        drain();
        repeat (n) pending_events.push_back(random_event());
        drain();
    endtask

    initial begin
        int half;
        model_width = WIDTH_RESET;
        model_channels = CHANNELS_RESET;
        wipe_stores();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed commands under the reset settings.
        pending_events.push_back(make_event(FN_RECORD, SEL_ENERGY, '0, 0, 0, 0));
        pending_events.push_back(make_event(FN_RECORD, SEL_ENERGY, '1, 511, 127, 1023));
        pending_events.push_back(make_event(FN_RECORD, SEL_NONE, 40'd4999999, 3, 1, 0));
        pending_events.push_back(make_event(FN_RECORD, SEL_MASS, 40'd5000000, 3, 1, 0));
        pending_events.push_back(make_event(FN_RECORD, SEL_ENERGY, 40'd249999999, 3, 1, 0));
        pending_events.push_back(make_event(FN_RECORD, SEL_ENERGY, 40'd250000000, 511, 0, 0));
        pending_events.push_back(make_event(FN_READ, SEL_ENERGY, '0, 0, 0, 0));
        pending_events.push_back(make_event(FN_READ, SEL_ENERGY, '0, 0, 0, 49));
        pending_events.push_back(make_event(FN_READ, SEL_ENERGY, '0, 0, 0, 1023));
        pending_events.push_back(make_event(FN_READ, SEL_MASS, '0, 511, 0, 0));
        pending_events.push_back(make_event(FN_READ, SEL_MASS, '0, 3, 0, 0));
        pending_events.push_back(make_event(FN_READ, SEL_NUCLIDE, '0, 511, 127, 0));
        pending_events.push_back(make_event(FN_READ, SEL_NUCLIDE, '0, 3, 1, 0));
        pending_events.push_back(make_event(FN_READ, SEL_NONE, '1, 3, 1, 1023));
        pending_events.push_back(make_event(FN_NOP, SEL_NONE, '1, 511, 127, 1023));
        pending_events.push_back(make_event(FN_CLEAR, SEL_ENERGY, '0, 0, 0, 0));
        pending_events.push_back(make_event(FN_READ, SEL_MASS, '0, 3, 0, 0));
        pending_events.push_back(make_event(FN_READ, SEL_ENERGY, '0, 0, 0, 49));
        pending_events.push_back(make_event(FN_RECORD, SEL_ENERGY, 40'd12345678, 3, 1, 0));
        pending_events.push_back(make_event(FN_READ, SEL_NUCLIDE, '0, 3, 1, 0));
        drain();

        // Random commands with the sender held back mid-phase until all results return.
        repeat (40) pending_events.push_back(random_event());
        drain();
        repeat (30) pending_events.push_back(random_event());
        half = 0;
        while (half < 15) begin
            @(negedge i_clk);
            half++;
        end
        hold_sender = 1'b1;
        while (push || awaited_results.size() > 0) @(negedge i_clk);
        hold_sender = 1'b0;
        drain();

        // Settings from one extreme to the other; zero channels counts as one.
        random_phase(32'd1, 32'd1024, 80);
        random_phase(32'd0, 32'd1, 60);
        random_phase(32'hFFFF_FFFF, 32'd2047, 60);
        random_phase(32'd1000, 32'd0, 60);
        random_phase(32'd3, 32'd1023, 80);
        random_phase(32'd37, 32'd200, 80);
        random_phase(32'd5000000, 32'd50, 60);

        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Run limit: covers the clearing sweeps with a wide margin.
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
